FILE: design/tfu_pkg.sv
package tfu_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned FMT_W       = 4;
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 4;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_FORMAT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_KIND   = 8'd1;

    // source formats
    localparam logic [FMT_W-1:0] FMT_RGBA32 = 4'd0;
    localparam logic [FMT_W-1:0] FMT_RGBA16 = 4'd1;
    localparam logic [FMT_W-1:0] FMT_IA16   = 4'd2;
    localparam logic [FMT_W-1:0] FMT_IA8    = 4'd3;
    localparam logic [FMT_W-1:0] FMT_IA4    = 4'd4;
    localparam logic [FMT_W-1:0] FMT_I8     = 4'd5;
    localparam logic [FMT_W-1:0] FMT_I4     = 4'd6;

    // target kinds
    localparam logic TARGET_COLOR = 1'b0;
    localparam logic TARGET_IA    = 1'b1;

    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'd255;

    // x / 3 == (x * 683) >> 11 for every x up to 3 * 255
    localparam int unsigned SUM_W      = 10;
    localparam int unsigned DIV3_SHIFT = 11;
    localparam logic [SUM_W-1:0] DIV3_MUL = 10'd683;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        OP_RGBA32_C,
        OP_IA16_C,
        OP_IA8_C,
        OP_IA4_C,
        OP_I8_C,
        OP_I4_C,
        OP_RGBA32_IA,
        OP_RGBA16_IA,
        OP_IA16_IA,
        OP_ERROR
    } tfu_op_t;

    typedef struct packed {
        tfu_op_t           op;
        logic [BYTE_W-1:0] byte_a;
        logic [BYTE_W-1:0] byte_b;
        logic [BYTE_W-1:0] byte_c;
        logic [BYTE_W-1:0] byte_d;
    } tfu_item_t;

endpackage

FILE: design/tfu_front.sv
module tfu_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tfu_pkg::BYTE_W-1:0]    s_byte_a,
    input  logic [tfu_pkg::BYTE_W-1:0]    s_byte_b,
    input  logic [tfu_pkg::BYTE_W-1:0]    s_byte_c,
    input  logic [tfu_pkg::BYTE_W-1:0]    s_byte_d,
    input  logic [tfu_pkg::FMT_W-1:0]     source_format,
    input  logic                          target_kind,
    output logic                          q_valid,
    output tfu_pkg::tfu_item_t            q_item,
    input  logic                          q_ready
);
    import tfu_pkg::*;

    logic      valid_reg, valid_next;
    tfu_item_t item_reg, item_next;
    tfu_op_t   op_class;

    // classify the item against the current configuration
    always_comb begin
        op_class = OP_ERROR;
        if (target_kind == TARGET_COLOR) begin
            case (source_format)
                FMT_RGBA32: op_class = OP_RGBA32_C;
                FMT_IA16:   op_class = OP_IA16_C;
                FMT_IA8:    op_class = OP_IA8_C;
                FMT_IA4:    op_class = OP_IA4_C;
                FMT_I8:     op_class = OP_I8_C;
                FMT_I4:     op_class = OP_I4_C;
                default:    op_class = OP_ERROR;
            endcase
        end else begin
            case (source_format)
                FMT_RGBA32: op_class = OP_RGBA32_IA;
                FMT_RGBA16: op_class = OP_RGBA16_IA;
                FMT_IA16:   op_class = OP_IA16_IA;
                default:    op_class = OP_ERROR;
            endcase
        end
    end

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_ready) begin
            valid_next = s_valid;
            if (s_valid) begin
                item_next.op     = op_class;
                item_next.byte_a = s_byte_a;
                item_next.byte_b = s_byte_b;
                item_next.byte_c = s_byte_c;
                item_next.byte_d = s_byte_d;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

endmodule

FILE: design/tfu_queue.sv
module tfu_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  tfu_pkg::tfu_item_t push_item,
    output logic               pop_valid,
    input  logic               pop,
    output tfu_pkg::tfu_item_t pop_item
);
    import tfu_pkg::*;

    tfu_item_t           entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) r = '0;
        else                               r = p + 1'b1;
        return r;
    endfunction

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) count_next = count_reg + 1'b1;
        if (!do_push && do_pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pointer_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");
`endif

endmodule

FILE: design/tfu_back.sv
module tfu_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    input  tfu_pkg::tfu_item_t         q_item,
    output logic                       q_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [tfu_pkg::BYTE_W-1:0] m_red,
    output logic [tfu_pkg::BYTE_W-1:0] m_green,
    output logic [tfu_pkg::BYTE_W-1:0] m_blue,
    output logic [tfu_pkg::BYTE_W-1:0] m_gray,
    output logic [tfu_pkg::BYTE_W-1:0] m_alpha,
    output logic                       m_format_error,
    output logic                       m_last_of_item
);
    import tfu_pkg::*;

    logic                          valid_reg, valid_next;
    logic                          phase_reg, phase_next;
    logic [BYTE_W-1:0]             red_reg, red_next;
    logic [BYTE_W-1:0]             green_reg, green_next;
    logic [BYTE_W-1:0]             blue_reg, blue_next;
    logic [BYTE_W-1:0]             gray_reg, gray_next;
    logic [BYTE_W-1:0]             alpha_reg, alpha_next;
    logic                          err_reg, err_next;
    logic                          last_reg, last_next;

    logic                          out_ok, emit, two_result;
    logic [3:0]                    nib;
    logic [4:0]                    r5, g5, b5;
    logic [SUM_W-1:0]              sum;
    logic [2*SUM_W-1:0]            product;
    logic [BYTE_W-1:0]             third;

    assign out_ok     = !valid_reg || m_ready;
    assign emit       = out_ok && q_valid;
    assign two_result = (q_item.op == OP_IA4_C) || (q_item.op == OP_I4_C);
    // first pass takes the low nibble, second the high one
    assign nib        = phase_reg ? q_item.byte_a[7:4] : q_item.byte_a[3:0];
    assign q_pop      = emit && (!two_result || phase_reg);

    assign r5 = q_item.byte_a[7:3];
    assign g5 = {q_item.byte_a[2:0], q_item.byte_b[7:6]};
    assign b5 = q_item.byte_b[5:1];

    always_comb begin
        if (q_item.op == OP_RGBA16_IA) begin
            sum = SUM_W'(r5) + SUM_W'(g5) + SUM_W'(b5);
        end else begin
            sum = SUM_W'(q_item.byte_a) + SUM_W'(q_item.byte_b) + SUM_W'(q_item.byte_c);
        end
        product = (2*SUM_W)'(sum) * (2*SUM_W)'(DIV3_MUL);
        third   = product[DIV3_SHIFT +: BYTE_W];
    end

    always_comb begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        gray_next  = gray_reg;
        alpha_next = alpha_reg;
        err_next   = err_reg;
        last_next  = last_reg;
        if (out_ok) begin
            valid_next = q_valid;
        end
        if (emit) begin
            phase_next = two_result && !phase_reg;
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
            gray_next  = '0;
            alpha_next = '0;
            err_next   = 1'b0;
            last_next  = 1'b1;
            case (q_item.op)
                OP_RGBA32_C: begin
                    red_next   = q_item.byte_a;
                    green_next = q_item.byte_b;
                    blue_next  = q_item.byte_c;
                    alpha_next = q_item.byte_d;
                end
                OP_IA16_C: begin
                    red_next   = q_item.byte_a;
                    green_next = q_item.byte_a;
                    blue_next  = q_item.byte_a;
                    alpha_next = q_item.byte_b;
                end
                OP_IA8_C: begin
                    red_next   = BYTE_W'(q_item.byte_a[7:4]);
                    green_next = BYTE_W'(q_item.byte_a[7:4]);
                    blue_next  = BYTE_W'(q_item.byte_a[7:4]);
                    alpha_next = BYTE_W'(q_item.byte_a[3:0]);
                end
                OP_IA4_C: begin
                    red_next   = BYTE_W'(nib[3:1]);
                    green_next = BYTE_W'(nib[3:1]);
                    blue_next  = BYTE_W'(nib[3:1]);
                    alpha_next = BYTE_W'(nib[0]);
                    last_next  = phase_reg;
                end
                OP_I8_C: begin
                    red_next   = q_item.byte_a;
                    green_next = q_item.byte_a;
                    blue_next  = q_item.byte_a;
                    alpha_next = ALPHA_OPAQUE;
                end
                OP_I4_C: begin
                    red_next   = BYTE_W'(nib);
                    green_next = BYTE_W'(nib);
                    blue_next  = BYTE_W'(nib);
                    alpha_next = ALPHA_OPAQUE;
                    last_next  = phase_reg;
                end
                OP_RGBA32_IA: begin
                    gray_next  = third;
                    alpha_next = q_item.byte_d;
                end
                OP_RGBA16_IA: begin
                    gray_next  = third;
                    alpha_next = BYTE_W'(q_item.byte_b[0]);
                end
                OP_IA16_IA: begin
                    gray_next  = q_item.byte_a;
                    alpha_next = q_item.byte_b;
                end
                default: begin
                    err_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        gray_reg  <= gray_next;
        alpha_reg <= alpha_next;
        err_reg   <= err_next;
        last_reg  <= last_next;
    end

    assign m_valid        = valid_reg;
    assign m_red          = red_reg;
    assign m_green        = green_reg;
    assign m_blue         = blue_reg;
    assign m_gray         = gray_reg;
    assign m_alpha        = alpha_reg;
    assign m_format_error = err_reg;
    assign m_last_of_item = last_reg;

`ifndef SYNTH
    a_phase_on_split: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> (q_valid && (q_item.op == OP_IA4_C || q_item.op == OP_I4_C)))
        else $error("second nibble pending without a split item at the head");

    a_first_half: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !last_reg) |-> phase_reg)
        else $error("first nibble shown with no second one pending");
`endif

endmodule

FILE: design/texel_format_unpacker_top.sv
// An item passes the front register, a queue entry and the result register.
// One input item per cycle while the output is not stalled and the queue has room;
// IA4 and I4 colour items are shown one nibble at a time, through the single result register.
// A two-entry queue separates classification from result generation.
// Reset (aresetn, synchronous, active low) empties the pipeline and clears
// source_format and target_kind to 0.
module texel_format_unpacker_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tfu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tfu_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [tfu_pkg::BYTE_W-1:0]      s_byte_a,
    input  logic [tfu_pkg::BYTE_W-1:0]      s_byte_b,
    input  logic [tfu_pkg::BYTE_W-1:0]      s_byte_c,
    input  logic [tfu_pkg::BYTE_W-1:0]      s_byte_d,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tfu_pkg::BYTE_W-1:0]      m_red,
    output logic [tfu_pkg::BYTE_W-1:0]      m_green,
    output logic [tfu_pkg::BYTE_W-1:0]      m_blue,
    output logic [tfu_pkg::BYTE_W-1:0]      m_gray,
    output logic [tfu_pkg::BYTE_W-1:0]      m_alpha,
    output logic                            m_format_error,
    output logic                            m_last_of_item
);
    import tfu_pkg::*;

    logic [FMT_W-1:0] source_format_reg, source_format_next;
    logic             target_kind_reg, target_kind_next;

    logic      fq_valid, fq_ready, bq_valid, bq_pop;
    tfu_item_t fq_item, bq_item;

    assign cfg_ready = 1'b1;

    // ignore writes to unknown indexes
    always_comb begin
        source_format_next = source_format_reg;
        target_kind_next   = target_kind_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_SOURCE_FORMAT: source_format_next = cfg_data[FMT_W-1:0];
                REG_TARGET_KIND:   target_kind_next   = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_format_reg <= '0;
            target_kind_reg   <= 1'b0;
        end else begin
            source_format_reg <= source_format_next;
            target_kind_reg   <= target_kind_next;
        end
    end

    tfu_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_byte_a      (s_byte_a),
        .s_byte_b      (s_byte_b),
        .s_byte_c      (s_byte_c),
        .s_byte_d      (s_byte_d),
        .source_format (source_format_reg),
        .target_kind   (target_kind_reg),
        .q_valid       (fq_valid),
        .q_item        (fq_item),
        .q_ready       (fq_ready)
    );

    tfu_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (bq_valid),
        .pop        (bq_pop),
        .pop_item   (bq_item)
    );

    tfu_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (bq_valid),
        .q_item         (bq_item),
        .q_pop          (bq_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_gray         (m_gray),
        .m_alpha        (m_alpha),
        .m_format_error (m_format_error),
        .m_last_of_item (m_last_of_item)
    );

endmodule
